[rtl/montgomery_reduce_unit_core_assert.svh]
// Assertion macros for the Montgomery reduction unit.
// Included by modules that check their own pipeline control; no other dependencies.
`ifndef MONTGOMERY_REDUCE_UNIT_CORE_ASSERT_SVH
`define MONTGOMERY_REDUCE_UNIT_CORE_ASSERT_SVH
`ifndef SYNTH
`define MRU_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
`define MRU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define MRU_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define MRU_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[rtl/mru_pkg.sv]
// Shared constants and types for the Montgomery reduction unit.
// No dependencies; imported by every module of the block.
package mru_pkg;

   localparam int DATA_WIDTH      = 32;
   localparam int OPERAND_WIDTH   = 64;
   localparam int RESULT_WIDTH    = 32;
   localparam int SHIFT_WIDTH     = 6;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int CSR_ADDR_WIDTH  = 4;
   localparam int STEPS_PER_STAGE = 4;

   localparam logic [CSR_DATA_WIDTH-1:0] MODULUS_RESET = 32'd1;
   localparam logic [SHIFT_WIDTH-1:0]    SHIFT_RESET   = 6'd32;
   localparam logic [CSR_DATA_WIDTH-1:0] NEG_INV_RESET = 32'd0;

   typedef enum logic [1:0] {
      REG_MODULUS = 2'd0,
      REG_SHIFT   = 2'd1,
      REG_NEG_INV = 2'd2
   } reg_index_type;

   typedef enum logic {
      CMD_REDUCE  = 1'b0,
      CMD_TO_FORM = 1'b1
   } cmd_type;

endpackage

[rtl/mru_csr.sv]
// Configuration registers: modulus, shift and negated inverse, plus the
// clamped shift and low-bit mask derived from them. Depends on mru_pkg.
module mru_csr import mru_pkg::*; #(
   parameter int WIDTH = DATA_WIDTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready,
   output logic [WIDTH-1:0]          modulus,
   output logic [WIDTH-1:0]          neg_inv,
   output logic [WIDTH-1:0]          low_mask,
   output logic [SHIFT_WIDTH-1:0]    shift_eff
);

   logic [CSR_DATA_WIDTH-1:0] modulus_ff;
   logic [SHIFT_WIDTH-1:0]    shift_ff;
   logic [CSR_DATA_WIDTH-1:0] neg_inv_ff;
   logic [SHIFT_WIDTH-1:0]    shift_eff_ff;
   logic [WIDTH-1:0]          low_mask_ff;
   logic                      wr_en;
   reg_index_type             reg_sel;

   function automatic logic [SHIFT_WIDTH-1:0] clamp_shift(input logic [SHIFT_WIDTH-1:0] raw);
      if (raw == '0) begin
         return SHIFT_WIDTH'(1);
      end else if (raw > SHIFT_WIDTH'(WIDTH)) begin
         return SHIFT_WIDTH'(WIDTH);
      end else begin
         return raw;
      end
   endfunction

   function automatic logic [WIDTH-1:0] shift_mask(input logic [SHIFT_WIDTH-1:0] n);
      return {WIDTH{1'b1}} >> (SHIFT_WIDTH'(WIDTH) - n);
   endfunction

   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = reg_index_type'(paddr[CSR_ADDR_WIDTH-1:2]);
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff   <= MODULUS_RESET;
         shift_ff     <= SHIFT_RESET;
         neg_inv_ff   <= NEG_INV_RESET;
         shift_eff_ff <= clamp_shift(SHIFT_RESET);
         low_mask_ff  <= shift_mask(clamp_shift(SHIFT_RESET));
      end else if (wr_en) begin
         case (reg_sel)
            REG_MODULUS: begin
               modulus_ff <= pwdata;
            end
            REG_SHIFT: begin
               shift_ff     <= pwdata[SHIFT_WIDTH-1:0];
               shift_eff_ff <= clamp_shift(pwdata[SHIFT_WIDTH-1:0]);
               low_mask_ff  <= shift_mask(clamp_shift(pwdata[SHIFT_WIDTH-1:0]));
            end
            REG_NEG_INV: begin
               neg_inv_ff <= pwdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_MODULUS: prdata = modulus_ff;
         REG_SHIFT:   prdata = CSR_DATA_WIDTH'(shift_ff);
         REG_NEG_INV: prdata = neg_inv_ff;
         default:     prdata = '0;
      endcase
   end

   assign modulus   = modulus_ff[WIDTH-1:0];
   assign neg_inv   = neg_inv_ff[WIDTH-1:0];
   assign low_mask  = low_mask_ff;
   assign shift_eff = shift_eff_ff;

endmodule

[rtl/mru_redc.sv]
// Pipelined REDC path: quotient multiply, modulus multiply, add and shift,
// final subtraction, then a delay line to match the pipe depth. Depends on mru_pkg.
module mru_redc import mru_pkg::*; #(
   parameter int WIDTH  = DATA_WIDTH,
   parameter int STAGES = 18
) (
   input  logic                     clock,
   input  logic                     advance,
   input  logic [OPERAND_WIDTH-1:0] operand,
   input  logic [WIDTH-1:0]         modulus,
   input  logic [WIDTH-1:0]         neg_inv,
   input  logic [WIDTH-1:0]         low_mask,
   input  logic [SHIFT_WIDTH-1:0]   shift_eff,
   output logic [WIDTH-1:0]         result,
   output logic                     too_large
);

   localparam int PROD_WIDTH = 2 * WIDTH;
   localparam int SUM_WIDTH  = OPERAND_WIDTH + 1;
   localparam int DLY        = STAGES - 4;

   logic [PROD_WIDTH-1:0]    quot_prod;
   logic [OPERAND_WIDTH-1:0] m1_ff;
   logic [WIDTH-1:0]         q_ff;
   logic [WIDTH-1:0]         q_in;
   logic [OPERAND_WIDTH-1:0] m2_ff;
   logic [PROD_WIDTH-1:0]    qp_ff;
   logic [PROD_WIDTH-1:0]    qp_in;
   logic [SUM_WIDTH-1:0]     sum;
   logic [SUM_WIDTH-1:0]     sum_shr;
   logic [OPERAND_WIDTH-1:0] limit;
   logic [OPERAND_WIDTH-1:0] t_ff;
   logic [OPERAND_WIDTH-1:0] t_in;
   logic                     big3_ff;
   logic                     big3_in;
   logic [OPERAND_WIDTH-1:0] mod_ext;
   logic [OPERAND_WIDTH-1:0] t_diff;
   logic [WIDTH-1:0]         res4_ff;
   logic [WIDTH-1:0]         res4_in;
   logic                     big4_ff;

   assign quot_prod = PROD_WIDTH'(operand[WIDTH-1:0]) * PROD_WIDTH'(neg_inv);
   assign q_in      = quot_prod[WIDTH-1:0] & low_mask;

   assign qp_in = PROD_WIDTH'(q_ff) * PROD_WIDTH'(modulus);

   assign sum     = {1'b0, m2_ff} + SUM_WIDTH'(qp_ff);
   assign sum_shr = sum >> shift_eff;
   assign t_in    = sum_shr[OPERAND_WIDTH-1:0];
   assign limit   = OPERAND_WIDTH'(modulus) << shift_eff;
   assign big3_in = (m2_ff >= limit);

   assign mod_ext = OPERAND_WIDTH'(modulus);
   assign t_diff  = t_ff - mod_ext;
   always_comb begin
      if (modulus == '0) begin
         res4_in = '0;
      end else if (t_ff >= mod_ext) begin
         res4_in = t_diff[WIDTH-1:0];
      end else begin
         res4_in = t_ff[WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         m1_ff   <= operand;
         q_ff    <= q_in;
         m2_ff   <= m1_ff;
         qp_ff   <= qp_in;
         t_ff    <= t_in;
         big3_ff <= big3_in;
         res4_ff <= res4_in;
         big4_ff <= big3_ff;
      end
   end

   if (DLY > 0) begin : g_dly
      logic [WIDTH-1:0] res_dly_ff [DLY];
      logic             big_dly_ff [DLY];

      always_ff @(posedge clock) begin
         if (advance) begin
            res_dly_ff[0] <= res4_ff;
            big_dly_ff[0] <= big4_ff;
            for (int k = 1; k < DLY; k++) begin
               res_dly_ff[k] <= res_dly_ff[k-1];
               big_dly_ff[k] <= big_dly_ff[k-1];
            end
         end
      end

      assign result    = res_dly_ff[DLY-1];
      assign too_large = big_dly_ff[DLY-1];
   end else begin : g_nodly
      assign result    = res4_ff;
      assign too_large = big4_ff;
   end

endmodule

[rtl/mru_tofm.sv]
// Pipelined bit-serial remainder chain for conversion into Montgomery form:
// streams the operand bits, then doubles once per shift position. Depends on mru_pkg.
module mru_tofm import mru_pkg::*; #(
   parameter int WIDTH  = DATA_WIDTH,
   parameter int STAGES = 24
) (
   input  logic                     clock,
   input  logic                     advance,
   input  logic [OPERAND_WIDTH-1:0] operand,
   input  logic [WIDTH-1:0]         modulus,
   input  logic [SHIFT_WIDTH-1:0]   shift_eff,
   output logic [WIDTH-1:0]         remainder
);

   localparam int STEPS = OPERAND_WIDTH + WIDTH;

   logic [WIDTH-1:0]         rem_ff  [STAGES];
   logic [WIDTH-1:0]         rem_in  [STAGES];
   logic [OPERAND_WIDTH-1:0] opnd_ff [STAGES-1];
   logic [OPERAND_WIDTH-1:0] opnd_in [STAGES-1];

   function automatic logic [WIDTH-1:0] mod_step(input logic [WIDTH-1:0] rem,
                                                 input logic bit_in,
                                                 input logic [WIDTH-1:0] mdl);
      logic [WIDTH:0] dbl;
      logic [WIDTH:0] dif;
      dbl = {rem, bit_in};
      dif = dbl - {1'b0, mdl};
      return (dbl >= {1'b0, mdl}) ? dif[WIDTH-1:0] : dbl[WIDTH-1:0];
   endfunction

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      logic [WIDTH-1:0]         chain [STEPS_PER_STAGE+1];
      logic [OPERAND_WIDTH-1:0] src;

      if (k == 0) begin : g_first
         assign chain[0] = '0;
         assign src      = operand;
      end else begin : g_next
         assign chain[0] = rem_ff[k-1];
         assign src      = opnd_ff[k-1];
      end

      for (genvar j = 0; j < STEPS_PER_STAGE; j++) begin : g_step
         localparam int Idx = k * STEPS_PER_STAGE + j;
         if (Idx < OPERAND_WIDTH) begin : g_bit
            assign chain[j+1] = mod_step(chain[j], src[OPERAND_WIDTH-1-Idx], modulus);
         end else if (Idx < STEPS) begin : g_dbl
            assign chain[j+1] = (shift_eff > SHIFT_WIDTH'(Idx - OPERAND_WIDTH)) ?
                                mod_step(chain[j], 1'b0, modulus) : chain[j];
         end else begin : g_pad
            assign chain[j+1] = chain[j];
         end
      end

      assign rem_in[k] = chain[STEPS_PER_STAGE];
      if (k < STAGES - 1) begin : g_pass
         assign opnd_in[k] = src;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < STAGES; k++) begin
            rem_ff[k] <= rem_in[k];
         end
         for (int k = 0; k < STAGES - 1; k++) begin
            opnd_ff[k] <= opnd_in[k];
         end
      end
   end

   assign remainder = rem_ff[STAGES-1];

endmodule

[rtl/montgomery_reduce_unit_core.sv]
// Montgomery reduction unit, top level. One item per cycle sustained while
// rsp_stall does not hold a waiting result. The depth is set by the
// remainder chain of the conversion path, four compare-subtract steps per stage.
// Synchronous reset clears all valid bits and loads modulus 1, shift 32, inverse 0.
// Depends on mru_pkg, mru_csr, mru_redc, mru_tofm and the assertion header.
`include "montgomery_reduce_unit_core_assert.svh"
module montgomery_reduce_unit_core import mru_pkg::*; #(
   parameter int WIDTH = DATA_WIDTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_command,
   input  logic [OPERAND_WIDTH-1:0]  req_operand,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [RESULT_WIDTH-1:0]   rsp_result,
   output logic                      rsp_too_large,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   localparam int STAGES = (OPERAND_WIDTH + WIDTH + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

   logic                    advance;
   logic [STAGES-1:0]       valid_ff;
   logic [STAGES-1:0]       valid_in;
   logic [STAGES-1:0]       cmd_ff;
   logic [STAGES-1:0]       cmd_in;
   logic                    rsp_valid_ff;
   logic [RESULT_WIDTH-1:0] rsp_result_ff;
   logic [RESULT_WIDTH-1:0] rsp_result_in;
   logic                    rsp_too_large_ff;
   logic                    rsp_too_large_in;

   logic [WIDTH-1:0]        modulus;
   logic [WIDTH-1:0]        neg_inv;
   logic [WIDTH-1:0]        low_mask;
   logic [SHIFT_WIDTH-1:0]  shift_eff;
   logic [WIDTH-1:0]        redc_result;
   logic                    redc_too_large;
   logic [WIDTH-1:0]        tofm_remainder;

   mru_csr #(
      .WIDTH(WIDTH)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (csr_psel),
      .penable   (csr_penable),
      .pwrite    (csr_pwrite),
      .paddr     (csr_paddr),
      .pwdata    (csr_pwdata),
      .prdata    (csr_prdata),
      .pready    (csr_pready),
      .modulus   (modulus),
      .neg_inv   (neg_inv),
      .low_mask  (low_mask),
      .shift_eff (shift_eff)
   );

   mru_redc #(
      .WIDTH (WIDTH),
      .STAGES(STAGES)
   ) u_redc (
      .clock     (clock),
      .advance   (advance),
      .operand   (req_operand),
      .modulus   (modulus),
      .neg_inv   (neg_inv),
      .low_mask  (low_mask),
      .shift_eff (shift_eff),
      .result    (redc_result),
      .too_large (redc_too_large)
   );

   mru_tofm #(
      .WIDTH (WIDTH),
      .STAGES(STAGES)
   ) u_tofm (
      .clock     (clock),
      .advance   (advance),
      .operand   (req_operand),
      .modulus   (modulus),
      .shift_eff (shift_eff),
      .remainder (tofm_remainder)
   );

   // hold the whole pipe while a result waits
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   assign valid_in = {valid_ff[STAGES-2:0], req_valid};
   assign cmd_in   = {cmd_ff[STAGES-2:0], req_command};

   always_comb begin
      if (cmd_ff[STAGES-1] == CMD_TO_FORM) begin
         rsp_result_in    = (modulus == '0) ? '0 : RESULT_WIDTH'(tofm_remainder);
         rsp_too_large_in = 1'b0;
      end else begin
         rsp_result_in    = RESULT_WIDTH'(redc_result);
         rsp_too_large_in = redc_too_large;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= valid_ff[STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cmd_ff           <= cmd_in;
         rsp_result_ff    <= rsp_result_in;
         rsp_too_large_ff <= rsp_too_large_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_result    = rsp_result_ff;
   assign rsp_too_large = rsp_too_large_ff;

   `MRU_ASSERT_NEXT(a_accept_enters, clock, reset, req_valid && !req_stall, valid_ff[0])
   `MRU_ASSERT_NEXT(a_frozen_holds, clock, reset, !advance, $stable(valid_ff))
   `MRU_ASSERT_NEXT(a_last_reaches_out, clock, reset, valid_ff[STAGES-1] && advance, rsp_valid)
   `MRU_ASSERT_IMPLY(a_empty_never_stalls, clock, reset, valid_ff == '0 && !rsp_valid_ff, !req_stall)

endmodule
